@@ src/sbspc_pkg.sv @@
// Package for the servo bus status packet checker.
// Holds verdict codes, protocol byte constants and the CRC-16 byte update.
// No dependencies.
`default_nettype none

package sbspc_pkg;

   // Verdict codes reported with each result
   localparam logic [2:0] VERDICT_BUSY   = 3'd0;
   localparam logic [2:0] VERDICT_OK     = 3'd1;
   localparam logic [2:0] VERDICT_BAD    = 3'd2;
   localparam logic [2:0] VERDICT_CRC    = 3'd3;
   localparam logic [2:0] VERDICT_DEVERR = 3'd4;

   // Protocol bytes
   localparam logic [7:0]  HDR_BYTE    = 8'hFF;
   localparam logic [7:0]  HDR_LAST    = 8'hFD;
   localparam logic [23:0] HDR_PATTERN = 24'hFFFFFD;
   localparam logic [7:0]  RSVD_BYTE   = 8'h00;
   localparam logic [7:0]  ID_MAX      = 8'hFC;
   localparam logic [7:0]  INST_STATUS = 8'h55;
   localparam logic [15:0] LEN_MIN     = 16'd4;
   localparam logic [15:0] MAX_LEN_RST = 16'd1024;
   localparam logic [15:0] CRC_POLY    = 16'h8005;

   // CRC-16, poly 0x8005, MSB first, one byte per call
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // CRC after the header bytes FF FF FD and reserved 00
   localparam logic [15:0] CRC_AFTER_HDR =
      crc_byte(crc_byte(crc_byte(crc_byte(16'h0000, HDR_BYTE), HDR_BYTE), HDR_LAST), RSVD_BYTE);

   // Result payload
   typedef struct packed {
      logic       frame_done;
      logic [2:0] verdict;
      logic [7:0] packet_id;
      logic [7:0] device_error;
      logic [7:0] param_byte;
      logic       param_valid;
   } result_type;

endpackage

`default_nettype wire

@@ src/sbspc_if.sv @@
// Channel interfaces for the servo bus status packet checker.
// Byte input, result output and register write channels; no dependencies.
`default_nettype none

interface sbspc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbspc_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_done;
   logic [2:0] verdict;
   logic [7:0] packet_id;
   logic [7:0] device_error;
   logic [7:0] param_byte;
   logic       param_valid;
   modport source (output valid, output frame_done, output verdict, output packet_id,
                   output device_error, output param_byte, output param_valid,
                   input ready);
   modport sink   (input valid, input frame_done, input verdict, input packet_id,
                   input device_error, input param_byte, input param_valid,
                   output ready);
endinterface

interface sbspc_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/servo_bus_status_packet_checker_top.sv @@
// Top level of the servo bus status packet checker.
// Uses sbspc_pkg and the channel interfaces in sbspc_if.sv.
//
//   channel  dir  payload                                         role
//   req_ch   in   rx_byte[7:0]                                    received bus bytes
//   rsp_ch   out  frame_done, verdict, packet_id, device_error,   one result per byte
//                 param_byte, param_valid
//   csr_ch   in   data[15:0]                                      max_length register
//
// One byte per cycle sustained while rsp_ch takes each result; the result is registered.
// Input register, then a single pass of parse and CRC logic into the result register.
// The result register is the only stall point: a stalled result holds while one
// more byte waits in the input register. Reset is synchronous and returns the
// parser to header hunt with max_length at 1024. csr_ch is always ready.
`default_nettype none

module servo_bus_status_packet_checker_top (
   input wire logic    clock,
   input wire logic    reset,
   sbspc_req_if.sink   req_ch,
   sbspc_rsp_if.source rsp_ch,
   sbspc_csr_if.sink   csr_ch
);

   // Parser phase codes
   localparam logic [3:0] PH_HUNT  = 4'd0;
   localparam logic [3:0] PH_ID    = 4'd1;
   localparam logic [3:0] PH_LEN_L = 4'd2;
   localparam logic [3:0] PH_LEN_H = 4'd3;
   localparam logic [3:0] PH_INST  = 4'd4;
   localparam logic [3:0] PH_ERR   = 4'd5;
   localparam logic [3:0] PH_PARAM = 4'd6;
   localparam logic [3:0] PH_CRC_L = 4'd7;
   localparam logic [3:0] PH_CRC_H = 4'd8;

   // Pipeline registers
   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff, in_byte_in;
   logic                    out_valid_ff, out_valid_in;
   sbspc_pkg::result_type   out_ff, out_in;

   // Parser state
   logic [23:0] recent_ff, recent_in;
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  len_low_ff, len_low_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  err_ff, err_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] max_len_ff, max_len_in;

   logic        advance;
   logic [7:0]  b;
   logic [15:0] crc_next;
   logic [15:0] len_full;
   logic [15:0] left_dec;
   logic        done;
   logic [2:0]  verdict;
   logic        pvalid;

   // Handshakes: result register frees when empty or taken
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign in_valid_in = req_ch.ready ? req_ch.valid : in_valid_ff;
   assign in_byte_in  = (req_ch.valid && req_ch.ready) ? req_ch.rx_byte : in_byte_ff;
   assign max_len_in  = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : max_len_ff;

   assign b        = in_byte_ff;
   assign crc_next = sbspc_pkg::crc_byte(crc_ff, b);
   assign len_full = {b, len_low_ff};
   assign left_dec = left_ff - 16'd1;

   // Parse one byte
   always_comb begin
      recent_in  = recent_ff;
      phase_in   = phase_ff;
      crc_in     = crc_ff;
      len_low_in = len_low_ff;
      left_in    = left_ff;
      id_in      = id_ff;
      err_in     = err_ff;
      crc_low_in = crc_low_ff;
      done       = 1'b0;
      verdict    = sbspc_pkg::VERDICT_BUSY;
      pvalid     = 1'b0;
      case (phase_ff)
         PH_ID: begin
            crc_in = crc_next;
            if (b > sbspc_pkg::ID_MAX) begin
               done = 1'b1; verdict = sbspc_pkg::VERDICT_BAD;
               phase_in = PH_HUNT; recent_in = '0;
            end else begin
               id_in = b; phase_in = PH_LEN_L;
            end
         end
         PH_LEN_L: begin
            crc_in = crc_next; len_low_in = b; phase_in = PH_LEN_H;
         end
         PH_LEN_H: begin
            crc_in = crc_next;
            if (len_full < sbspc_pkg::LEN_MIN || len_full > max_len_ff) begin
               done = 1'b1; verdict = sbspc_pkg::VERDICT_BAD;
               phase_in = PH_HUNT; recent_in = '0;
            end else begin
               left_in = len_full - sbspc_pkg::LEN_MIN; phase_in = PH_INST;
            end
         end
         PH_INST: begin
            crc_in = crc_next;
            if (b != sbspc_pkg::INST_STATUS) begin
               done = 1'b1; verdict = sbspc_pkg::VERDICT_BAD;
               phase_in = PH_HUNT; recent_in = '0;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_ERR: begin
            crc_in   = crc_next;
            err_in   = b;
            phase_in = (left_ff != 16'd0) ? PH_PARAM : PH_CRC_L;
         end
         PH_PARAM: begin
            crc_in  = crc_next;
            pvalid  = 1'b1;
            left_in = left_dec;
            if (left_dec == 16'd0) begin
               phase_in = PH_CRC_L;
            end
         end
         PH_CRC_L: begin
            crc_low_in = b; phase_in = PH_CRC_H;
         end
         PH_CRC_H: begin
            done = 1'b1;
            if ({b, crc_low_ff} != crc_ff) begin
               verdict = sbspc_pkg::VERDICT_CRC;
            end else if (err_ff != 8'd0) begin
               verdict = sbspc_pkg::VERDICT_DEVERR;
            end else begin
               verdict = sbspc_pkg::VERDICT_OK;
            end
            phase_in = PH_HUNT; recent_in = '0;
         end
         default: begin
            // header hunt; FF FF FD FD is a stuffed header
            if (recent_ff == sbspc_pkg::HDR_PATTERN && b != sbspc_pkg::HDR_LAST) begin
               recent_in = '0;
               if (b == sbspc_pkg::RSVD_BYTE) begin
                  crc_in   = sbspc_pkg::CRC_AFTER_HDR;
                  id_in    = 8'd0;
                  err_in   = 8'd0;
                  phase_in = PH_ID;
               end else begin
                  done = 1'b1; verdict = sbspc_pkg::VERDICT_BAD;
                  phase_in = PH_HUNT;
               end
            end else begin
               phase_in  = PH_HUNT;
               recent_in = {recent_ff[15:0], b};
            end
         end
      endcase
   end

   // Result register contents
   always_comb begin
      out_in.frame_done   = done;
      out_in.verdict      = verdict;
      out_in.packet_id    = id_in;
      out_in.device_error = err_in;
      out_in.param_byte   = pvalid ? b : 8'd0;
      out_in.param_valid  = pvalid;
   end

   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_ch.ready);

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         recent_ff    <= '0;
         phase_ff     <= PH_HUNT;
         crc_ff       <= '0;
         len_low_ff   <= '0;
         left_ff      <= '0;
         id_ff        <= '0;
         err_ff       <= '0;
         crc_low_ff   <= '0;
         max_len_ff   <= sbspc_pkg::MAX_LEN_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         max_len_ff   <= max_len_in;
         if (advance) begin
            recent_ff  <= recent_in;
            phase_ff   <= phase_in;
            crc_ff     <= crc_in;
            len_low_ff <= len_low_in;
            left_ff    <= left_in;
            id_ff      <= id_in;
            err_ff     <= err_in;
            crc_low_ff <= crc_low_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.frame_done   = out_ff.frame_done;
   assign rsp_ch.verdict      = out_ff.verdict;
   assign rsp_ch.packet_id    = out_ff.packet_id;
   assign rsp_ch.device_error = out_ff.device_error;
   assign rsp_ch.param_byte   = out_ff.param_byte;
   assign rsp_ch.param_valid  = out_ff.param_valid;

   // Checks
   a_done_has_verdict: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.frame_done |-> out_ff.verdict != sbspc_pkg::VERDICT_BUSY)
      else $error("finished packet without verdict");

   a_busy_verdict: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.frame_done |-> out_ff.verdict == sbspc_pkg::VERDICT_BUSY)
      else $error("verdict given while packet in progress");

   a_param_not_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.param_valid |-> !out_ff.frame_done)
      else $error("parameter byte flagged on packet end");

   a_done_rehunt: assert property (@(posedge clock) disable iff (reset)
      advance && done |=> phase_ff == PH_HUNT && recent_ff == 24'd0)
      else $error("parser did not return to hunt after packet end");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ch.ready |=> in_valid_ff)
      else $error("queued byte dropped during result stall");

endmodule

`default_nettype wire
